>>> design/tbw_pkg.sv
// ----------------------------------------------------------------------------
// Triangle blend weights package
// Shared types, field widths, command codes and datapath status.
// ----------------------------------------------------------------------------
package tbw_pkg;

    localparam int COORD_W   = 16;
    localparam int DIFF_W    = 17;
    localparam int OPND_W    = 27;
    localparam int PROD_W    = 54;
    localparam int SUM_W     = 55;
    localparam int TURN_W    = 36;
    localparam int MAG_W     = 26;
    localparam int DIST_W    = 51;
    localparam int WGT_W     = 17;
    localparam int IDX_W     = 4;
    localparam int SLOT_W    = 5;
    localparam int CNT_W     = 6;
    localparam int DIV_STEPS = 17;

    localparam logic [WGT_W-1:0] W_ONE = 17'h10000;

    localparam logic [1:0] ACT_LOAD_POINT = 2'd0;
    localparam logic [1:0] ACT_LOAD_TRI   = 2'd1;
    localparam logic [1:0] ACT_QUERY      = 2'd2;

    localparam logic [1:0] CORNER_A = 2'd0;
    localparam logic [1:0] CORNER_B = 2'd1;
    localparam logic [1:0] CORNER_C = 2'd2;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    localparam logic [2:0] OP_WHOLE = 3'd0;
    localparam logic [2:0] OP_NA    = 3'd1;
    localparam logic [2:0] OP_NB    = 3'd2;
    localparam logic [2:0] OP_LEN   = 3'd3;
    localparam logic [2:0] OP_DOT   = 3'd4;
    localparam logic [2:0] OP_OX    = 3'd5;
    localparam logic [2:0] OP_OY    = 3'd6;
    localparam logic [2:0] OP_DIST  = 3'd7;

    localparam logic [1:0] DIV_WA = 2'd0;
    localparam logic [1:0] DIV_WB = 2'd1;
    localparam logic [1:0] DIV_T  = 2'd2;

    localparam logic [1:0] T_KEEP = 2'd0;
    localparam logic [1:0] T_ZERO = 2'd1;
    localparam logic [1:0] T_ONE  = 2'd2;

    localparam logic [2:0] EMIT_NONE   = 3'd0;
    localparam logic [2:0] EMIT_A      = 3'd1;
    localparam logic [2:0] EMIT_B      = 3'd2;
    localparam logic [2:0] EMIT_C      = 3'd3;
    localparam logic [2:0] EMIT_FROM   = 3'd4;
    localparam logic [2:0] EMIT_TO     = 3'd5;
    localparam logic [2:0] EMIT_SINGLE = 3'd6;

    typedef struct packed {
        logic [1:0]              action;
        logic [SLOT_W-1:0]       slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } in_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] point_index;
        logic [WGT_W-1:0] weight;
        logic             last;
    } out_item_t;

    typedef struct packed {
        logic              tri_rd;
        logic [SLOT_W-1:0] tri_idx;
        logic              pt_rd;
        logic [1:0]        pt_sel;
        logic [1:0]        edge_sel;
        logic              mac_go;
        logic [2:0]        mac_op;
        logic              div_go;
        logic [1:0]        div_sel;
        logic [1:0]        t_set;
        logic              best_upd;
        logic [2:0]        emit;
    } cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic div_busy;
        logic whole_zero;
        logic contained;
        logic len_zero;
        logic dot_le0;
        logic dot_ge_len;
        logic best_single;
    } status_t;

endpackage

>>> design/tbw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tbw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/tbw_datapath.sv
// ----------------------------------------------------------------------------
// Triangle blend weights datapath
// Point and triangle tables, a pipelined dual multiply-accumulate unit,
// a restoring divider, best-edge tracking and the result register.
// ----------------------------------------------------------------------------
module tbw_datapath #(
    parameter int MAX_POINTS    = 16,
    parameter int MAX_TRIANGLES = 32,
    parameter int COORD_BITS    = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  tbw_pkg::in_item_t   item,
    input  tbw_pkg::cmd_t       cmd,
    output tbw_pkg::status_t    status,
    output tbw_pkg::out_item_t  result,
    output logic                result_valid
);

    localparam int CW  = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int PD  = (MAX_POINTS < 16) ? MAX_POINTS : 16;
    localparam int TD  = (MAX_TRIANGLES < 32) ? MAX_TRIANGLES : 32;
    localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
    localparam int TAW = (TD > 1) ? $clog2(TD) : 1;

    typedef logic signed [tbw_pkg::COORD_W-1:0] coord_t;
    typedef logic signed [tbw_pkg::OPND_W-1:0]  opnd_t;
    typedef logic signed [tbw_pkg::TURN_W-1:0]  turn_t;

    function automatic coord_t sext(input logic [CW-1:0] v);
        logic signed [CW-1:0] s;
        s = v;
        return tbw_pkg::COORD_W'(s);
    endfunction

    function automatic opnd_t dif(input coord_t u, input coord_t v);
        logic signed [tbw_pkg::DIFF_W-1:0] d;
        d = tbw_pkg::DIFF_W'(u) - tbw_pkg::DIFF_W'(v);
        return tbw_pkg::OPND_W'(d);
    endfunction

    function automatic logic [tbw_pkg::TURN_W-1:0] mag36(input turn_t v);
        return v[tbw_pkg::TURN_W-1] ? tbw_pkg::TURN_W'(-v) : tbw_pkg::TURN_W'(v);
    endfunction

    // ---------------- tables ----------------
    logic                  pt_we;
    logic                  tri_we;
    logic [2*CW-1:0]       pt_rdata;
    logic [11:0]           tri_rdata;
    logic [tbw_pkg::IDX_W-1:0] rd_corner;
    logic                  rd_in_range;

    assign pt_we  = accept && (item.action == tbw_pkg::ACT_LOAD_POINT)
                    && ({1'b0, item.slot} < 6'(PD));
    assign tri_we = accept && (item.action == tbw_pkg::ACT_LOAD_TRI)
                    && ({1'b0, item.slot} < 6'(TD));

    logic [11:0] tri_reg;

    always_comb
    begin
        case (cmd.pt_sel)
            tbw_pkg::CORNER_A: rd_corner = tri_reg[3:0];
            tbw_pkg::CORNER_B: rd_corner = tri_reg[7:4];
            default:           rd_corner = tri_reg[11:8];
        endcase
    end

    assign rd_in_range = {1'b0, rd_corner} < 5'(PD);

    tbw_ram #(.WIDTH(2*CW), .DEPTH(PD)) u_pt_ram (
        .clk   (clk),
        .we    (pt_we),
        .waddr (item.slot[PAW-1:0]),
        .wdata ({item.pos_y[CW-1:0], item.pos_x[CW-1:0]}),
        .raddr (rd_corner[PAW-1:0]),
        .rdata (pt_rdata)
    );

    tbw_ram #(.WIDTH(12), .DEPTH(TD)) u_tri_ram (
        .clk   (clk),
        .we    (tri_we),
        .waddr (item.slot[TAW-1:0]),
        .wdata ({item.corner_c, item.corner_b, item.corner_a}),
        .raddr (cmd.tri_idx[TAW-1:0]),
        .rdata (tri_rdata)
    );

    logic       tri_pend_reg;
    logic       pt_pend_reg;
    logic [1:0] pt_pend_sel_reg;
    logic       pt_pend_in_reg;
    coord_t     rd_x, rd_y;
    coord_t     px_reg, py_reg, ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    assign rd_x = pt_pend_in_reg ? sext(pt_rdata[CW-1:0]) : '0;
    assign rd_y = pt_pend_in_reg ? sext(pt_rdata[2*CW-1:CW]) : '0;

    // ---------------- edge selection ----------------
    coord_t sx, sy, ex, ey;
    logic [tbw_pkg::IDX_W-1:0] s_idx, e_idx;

    always_comb
    begin
        case (cmd.edge_sel)
            tbw_pkg::EDGE_AB:
            begin
                sx = ax_reg; sy = ay_reg; ex = bx_reg; ey = by_reg;
                s_idx = tri_reg[3:0]; e_idx = tri_reg[7:4];
            end
            tbw_pkg::EDGE_BC:
            begin
                sx = bx_reg; sy = by_reg; ex = cx_reg; ey = cy_reg;
                s_idx = tri_reg[7:4]; e_idx = tri_reg[11:8];
            end
            default:
            begin
                sx = cx_reg; sy = cy_reg; ex = ax_reg; ey = ay_reg;
                s_idx = tri_reg[11:8]; e_idx = tri_reg[3:0];
            end
        endcase
    end

    // ---------------- multiply-accumulate pipeline ----------------
    logic [tbw_pkg::WGT_W-1:0]  t_reg, wa_reg, wb_reg;
    logic [tbw_pkg::MAG_W-1:0]  mx_reg, my_reg;
    turn_t whole_reg, na_reg, nb_reg, len_reg, dot_reg;
    logic [tbw_pkg::DIST_W-1:0] dist_reg;

    opnd_t op_a, op_b, op_c, op_d;
    logic  op_sub;
    opnd_t unit_one;
    opnd_t t_opnd;

    assign unit_one = tbw_pkg::OPND_W'(tbw_pkg::W_ONE);
    assign t_opnd   = tbw_pkg::OPND_W'(t_reg);

    always_comb
    begin
        op_sub = 1'b0;
        unique case (cmd.mac_op)
            tbw_pkg::OP_WHOLE:
            begin
                op_a = dif(bx_reg, ax_reg); op_b = dif(cy_reg, ay_reg);
                op_c = dif(by_reg, ay_reg); op_d = dif(cx_reg, ax_reg);
                op_sub = 1'b1;
            end
            tbw_pkg::OP_NA:
            begin
                op_a = dif(bx_reg, px_reg); op_b = dif(cy_reg, py_reg);
                op_c = dif(by_reg, py_reg); op_d = dif(cx_reg, px_reg);
                op_sub = 1'b1;
            end
            tbw_pkg::OP_NB:
            begin
                op_a = dif(px_reg, ax_reg); op_b = dif(cy_reg, ay_reg);
                op_c = dif(py_reg, ay_reg); op_d = dif(cx_reg, ax_reg);
                op_sub = 1'b1;
            end
            tbw_pkg::OP_LEN:
            begin
                op_a = dif(ex, sx); op_b = dif(ex, sx);
                op_c = dif(ey, sy); op_d = dif(ey, sy);
            end
            tbw_pkg::OP_DOT:
            begin
                op_a = dif(px_reg, sx); op_b = dif(ex, sx);
                op_c = dif(py_reg, sy); op_d = dif(ey, sy);
            end
            tbw_pkg::OP_OX:
            begin
                op_a = t_opnd; op_b = dif(ex, sx);
                op_c = dif(sx, px_reg); op_d = unit_one;
            end
            tbw_pkg::OP_OY:
            begin
                op_a = t_opnd; op_b = dif(ey, sy);
                op_c = dif(sy, py_reg); op_d = unit_one;
            end
            default:
            begin
                op_a = tbw_pkg::OPND_W'(mx_reg); op_b = tbw_pkg::OPND_W'(mx_reg);
                op_c = tbw_pkg::OPND_W'(my_reg); op_d = tbw_pkg::OPND_W'(my_reg);
            end
        endcase
    end

    logic  s1_v_reg, s2_v_reg;
    opnd_t s1_a_reg, s1_b_reg, s1_c_reg, s1_d_reg;
    logic  s1_sub_reg, s2_sub_reg;
    logic [2:0] s1_op_reg, s2_op_reg;
    logic signed [tbw_pkg::PROD_W-1:0] p1_reg, p2_reg;
    logic signed [tbw_pkg::SUM_W-1:0]  sum;
    logic [tbw_pkg::SUM_W-1:0]         sum_mag;

    assign sum = s2_sub_reg ? tbw_pkg::SUM_W'(p1_reg) - tbw_pkg::SUM_W'(p2_reg)
                            : tbw_pkg::SUM_W'(p1_reg) + tbw_pkg::SUM_W'(p2_reg);
    assign sum_mag = sum[tbw_pkg::SUM_W-1] ? tbw_pkg::SUM_W'(-sum) : tbw_pkg::SUM_W'(sum);

    // ---------------- divider ----------------
    logic                         div_busy_reg;
    logic [4:0]                   div_cnt_reg;
    logic [tbw_pkg::TURN_W-1:0]   div_rem_reg, div_den_reg;
    logic [tbw_pkg::WGT_W-1:0]    div_quo_reg;
    logic [1:0]                   div_dst_reg;
    logic [tbw_pkg::TURN_W:0]     div_trial;
    logic                         div_ge;
    logic [tbw_pkg::TURN_W-1:0]   div_rem_next;
    logic [tbw_pkg::WGT_W-1:0]    div_quo_next;
    logic [tbw_pkg::TURN_W-1:0]   div_num, div_den;

    always_comb
    begin
        case (cmd.div_sel)
            tbw_pkg::DIV_WA:
            begin
                div_num = mag36(na_reg); div_den = mag36(whole_reg);
            end
            tbw_pkg::DIV_WB:
            begin
                div_num = mag36(nb_reg); div_den = mag36(whole_reg);
            end
            default:
            begin
                div_num = dot_reg; div_den = len_reg;
            end
        endcase
    end

    assign div_trial    = (div_cnt_reg == 5'(tbw_pkg::DIV_STEPS)) ? {1'b0, div_rem_reg}
                                                                  : {div_rem_reg, 1'b0};
    assign div_ge       = div_trial >= {1'b0, div_den_reg};
    assign div_rem_next = tbw_pkg::TURN_W'(div_ge ? div_trial - {1'b0, div_den_reg}
                                                  : div_trial);
    assign div_quo_next = {div_quo_reg[tbw_pkg::WGT_W-2:0], div_ge};

    // ---------------- best edge and results ----------------
    logic                        found_reg;
    logic [tbw_pkg::DIST_W-1:0]  best_reg;
    logic [tbw_pkg::WGT_W-1:0]   best_t_reg;
    logic [tbw_pkg::IDX_W-1:0]   best_from_reg, best_to_reg;
    logic                        result_valid_reg;
    tbw_pkg::out_item_t          result_reg;
    tbw_pkg::out_item_t          result_next;
    turn_t                       nc;

    assign nc = whole_reg - na_reg - nb_reg;

    always_comb
    begin
        result_next = result_reg;
        case (cmd.emit)
            tbw_pkg::EMIT_A:    result_next = '{tri_reg[3:0], wa_reg, 1'b0};
            tbw_pkg::EMIT_B:    result_next = '{tri_reg[7:4], wb_reg, 1'b0};
            tbw_pkg::EMIT_C:    result_next = '{tri_reg[11:8],
                                               tbw_pkg::W_ONE - wa_reg - wb_reg, 1'b1};
            tbw_pkg::EMIT_FROM: result_next = '{best_from_reg,
                                               tbw_pkg::W_ONE - best_t_reg, 1'b0};
            tbw_pkg::EMIT_TO:   result_next = '{best_to_reg, best_t_reg, 1'b1};
            tbw_pkg::EMIT_SINGLE:
                result_next = '{found_reg ? best_from_reg : '0, tbw_pkg::W_ONE, 1'b1};
            default:            result_next = result_reg;
        endcase
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tri_pend_reg     <= 1'b0;
            pt_pend_reg      <= 1'b0;
            s1_v_reg         <= 1'b0;
            s2_v_reg         <= 1'b0;
            div_busy_reg     <= 1'b0;
            div_cnt_reg      <= '0;
            found_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            tri_pend_reg     <= cmd.tri_rd;
            pt_pend_reg      <= cmd.pt_rd;
            s1_v_reg         <= cmd.mac_go;
            s2_v_reg         <= s1_v_reg;
            result_valid_reg <= cmd.emit != tbw_pkg::EMIT_NONE;
            if (cmd.div_go)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= 5'(tbw_pkg::DIV_STEPS);
            end
            else if (div_busy_reg)
            begin
                div_cnt_reg <= div_cnt_reg - 5'd1;
                if (div_cnt_reg == 5'd1)
                begin
                    div_busy_reg <= 1'b0;
                end
            end
            if (accept && item.action == tbw_pkg::ACT_QUERY)
            begin
                found_reg <= 1'b0;
            end
            else if (cmd.best_upd)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept && item.action == tbw_pkg::ACT_QUERY)
        begin
            px_reg <= sext(item.pos_x[CW-1:0]);
            py_reg <= sext(item.pos_y[CW-1:0]);
        end
        if (tri_pend_reg)
        begin
            tri_reg <= tri_rdata;
        end
        pt_pend_sel_reg <= cmd.pt_sel;
        pt_pend_in_reg  <= rd_in_range;
        if (pt_pend_reg)
        begin
            case (pt_pend_sel_reg)
                tbw_pkg::CORNER_A:
                begin
                    ax_reg <= rd_x; ay_reg <= rd_y;
                end
                tbw_pkg::CORNER_B:
                begin
                    bx_reg <= rd_x; by_reg <= rd_y;
                end
                default:
                begin
                    cx_reg <= rd_x; cy_reg <= rd_y;
                end
            endcase
        end

        s1_a_reg   <= op_a;
        s1_b_reg   <= op_b;
        s1_c_reg   <= op_c;
        s1_d_reg   <= op_d;
        s1_sub_reg <= op_sub;
        s1_op_reg  <= cmd.mac_op;
        p1_reg     <= s1_a_reg * s1_b_reg;
        p2_reg     <= s1_c_reg * s1_d_reg;
        s2_sub_reg <= s1_sub_reg;
        s2_op_reg  <= s1_op_reg;
        if (s2_v_reg)
        begin
            unique case (s2_op_reg)
                tbw_pkg::OP_WHOLE: whole_reg <= tbw_pkg::TURN_W'(sum);
                tbw_pkg::OP_NA:    na_reg    <= tbw_pkg::TURN_W'(sum);
                tbw_pkg::OP_NB:    nb_reg    <= tbw_pkg::TURN_W'(sum);
                tbw_pkg::OP_LEN:   len_reg   <= tbw_pkg::TURN_W'(sum);
                tbw_pkg::OP_DOT:   dot_reg   <= tbw_pkg::TURN_W'(sum);
                tbw_pkg::OP_OX:    mx_reg    <= tbw_pkg::MAG_W'(sum_mag >> 8);
                tbw_pkg::OP_OY:    my_reg    <= tbw_pkg::MAG_W'(sum_mag >> 8);
                default:           dist_reg  <= tbw_pkg::DIST_W'(sum);
            endcase
        end

        if (cmd.div_go)
        begin
            div_rem_reg <= div_num;
            div_den_reg <= div_den;
            div_quo_reg <= '0;
            div_dst_reg <= cmd.div_sel;
        end
        else if (div_busy_reg)
        begin
            div_rem_reg <= div_rem_next;
            div_quo_reg <= div_quo_next;
            if (div_cnt_reg == 5'd1)
            begin
                case (div_dst_reg)
                    tbw_pkg::DIV_WA: wa_reg <= div_quo_next;
                    tbw_pkg::DIV_WB: wb_reg <= div_quo_next;
                    default:         t_reg  <= div_quo_next;
                endcase
            end
        end
        if (cmd.t_set == tbw_pkg::T_ZERO)
        begin
            t_reg <= '0;
        end
        else if (cmd.t_set == tbw_pkg::T_ONE)
        begin
            t_reg <= tbw_pkg::W_ONE;
        end

        if (cmd.best_upd && (!found_reg || dist_reg < best_reg))
        begin
            best_reg      <= dist_reg;
            best_t_reg    <= t_reg;
            best_from_reg <= s_idx;
            best_to_reg   <= e_idx;
        end
        result_reg <= result_next;
    end

    assign status.mac_busy    = s1_v_reg || s2_v_reg;
    assign status.div_busy    = div_busy_reg;
    assign status.whole_zero  = whole_reg == '0;
    assign status.contained   = (na_reg == '0 || na_reg[tbw_pkg::TURN_W-1] == whole_reg[tbw_pkg::TURN_W-1])
                             && (nb_reg == '0 || nb_reg[tbw_pkg::TURN_W-1] == whole_reg[tbw_pkg::TURN_W-1])
                             && (nc == '0 || nc[tbw_pkg::TURN_W-1] == whole_reg[tbw_pkg::TURN_W-1]);
    assign status.len_zero    = len_reg == '0;
    assign status.dot_le0     = dot_reg[tbw_pkg::TURN_W-1] || dot_reg == '0;
    assign status.dot_ge_len  = dot_reg >= len_reg;
    assign status.best_single = !found_reg || best_from_reg == best_to_reg;

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

>>> design/tbw_ctrl.sv
// ----------------------------------------------------------------------------
// Triangle blend weights controller
// Holds the triangle count and sequences the containment walk, the edge
// search and the result emission.
// ----------------------------------------------------------------------------
module tbw_ctrl #(
    parameter int MAX_TRIANGLES = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        accept,
    input  logic [1:0]                  action,
    input  logic                        wr_en,
    input  logic [tbw_pkg::CNT_W-1:0]   wr_data,
    input  tbw_pkg::status_t            status,
    output tbw_pkg::cmd_t               cmd,
    output logic                        busy
);

    localparam int TD = (MAX_TRIANGLES < 32) ? MAX_TRIANGLES : 32;

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_FT     = 5'd1;
    localparam logic [4:0] S_FW     = 5'd2;
    localparam logic [4:0] S_FA     = 5'd3;
    localparam logic [4:0] S_FB     = 5'd4;
    localparam logic [4:0] S_FC     = 5'd5;
    localparam logic [4:0] S_FD     = 5'd6;
    localparam logic [4:0] S_CWH    = 5'd7;
    localparam logic [4:0] S_CNA    = 5'd8;
    localparam logic [4:0] S_CNB    = 5'd9;
    localparam logic [4:0] S_CWAIT  = 5'd10;
    localparam logic [4:0] S_CCHK   = 5'd11;
    localparam logic [4:0] S_DWAW   = 5'd12;
    localparam logic [4:0] S_DWBW   = 5'd13;
    localparam logic [4:0] S_EA     = 5'd14;
    localparam logic [4:0] S_EB     = 5'd15;
    localparam logic [4:0] S_EC     = 5'd16;
    localparam logic [4:0] S_ELEN   = 5'd17;
    localparam logic [4:0] S_EDOT   = 5'd18;
    localparam logic [4:0] S_EWAIT  = 5'd19;
    localparam logic [4:0] S_ECHK   = 5'd20;
    localparam logic [4:0] S_EDIVW  = 5'd21;
    localparam logic [4:0] S_EOX    = 5'd22;
    localparam logic [4:0] S_EOY    = 5'd23;
    localparam logic [4:0] S_EWAIT2 = 5'd24;
    localparam logic [4:0] S_EDIST  = 5'd25;
    localparam logic [4:0] S_EWAIT3 = 5'd26;
    localparam logic [4:0] S_EUPD   = 5'd27;
    localparam logic [4:0] S_OUT    = 5'd28;
    localparam logic [4:0] S_OUT2   = 5'd29;

    logic [4:0]                  state_reg, state_next;
    logic [tbw_pkg::CNT_W-1:0]   count_reg;
    logic [tbw_pkg::CNT_W-1:0]   tri_reg, tri_next;
    logic [1:0]                  edge_reg, edge_next;
    logic                        phase_reg, phase_next;
    logic [tbw_pkg::CNT_W-1:0]   n_used;
    logic [tbw_pkg::CNT_W-1:0]   tri_inc;
    logic                        advance;

    assign n_used  = (count_reg > tbw_pkg::CNT_W'(TD)) ? tbw_pkg::CNT_W'(TD) : count_reg;
    assign tri_inc = tri_reg + tbw_pkg::CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        tri_next     = tri_reg;
        edge_next    = edge_reg;
        phase_next   = phase_reg;
        advance      = 1'b0;
        cmd          = '0;
        cmd.tri_idx  = tri_reg[tbw_pkg::SLOT_W-1:0];
        cmd.edge_sel = edge_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && action == tbw_pkg::ACT_QUERY)
                begin
                    tri_next   = '0;
                    edge_next  = tbw_pkg::EDGE_AB;
                    phase_next = 1'b0;
                    state_next = (n_used == '0) ? S_OUT : S_FT;
                end
            end
            S_FT:
            begin
                cmd.tri_rd = 1'b1;
                state_next = S_FW;
            end
            S_FW: state_next = S_FA;
            S_FA:
            begin
                cmd.pt_rd  = 1'b1;
                cmd.pt_sel = tbw_pkg::CORNER_A;
                state_next = S_FB;
            end
            S_FB:
            begin
                cmd.pt_rd  = 1'b1;
                cmd.pt_sel = tbw_pkg::CORNER_B;
                state_next = S_FC;
            end
            S_FC:
            begin
                cmd.pt_rd  = 1'b1;
                cmd.pt_sel = tbw_pkg::CORNER_C;
                state_next = S_FD;
            end
            S_FD: state_next = phase_reg ? S_ELEN : S_CWH;
            S_CWH:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_WHOLE;
                state_next = S_CNA;
            end
            S_CNA:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_NA;
                state_next = S_CNB;
            end
            S_CNB:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_NB;
                state_next = S_CWAIT;
            end
            S_CWAIT:
            begin
                if (!status.mac_busy)
                begin
                    state_next = S_CCHK;
                end
            end
            S_CCHK:
            begin
                if (!status.whole_zero && status.contained)
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = tbw_pkg::DIV_WA;
                    state_next  = S_DWAW;
                end
                else if (tri_inc == n_used)
                begin
                    phase_next = 1'b1;
                    tri_next   = '0;
                    edge_next  = tbw_pkg::EDGE_AB;
                    state_next = S_FT;
                end
                else
                begin
                    tri_next   = tri_inc;
                    state_next = S_FT;
                end
            end
            S_DWAW:
            begin
                if (!status.div_busy)
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = tbw_pkg::DIV_WB;
                    state_next  = S_DWBW;
                end
            end
            S_DWBW:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_EA;
                end
            end
            S_EA:
            begin
                cmd.emit   = tbw_pkg::EMIT_A;
                state_next = S_EB;
            end
            S_EB:
            begin
                cmd.emit   = tbw_pkg::EMIT_B;
                state_next = S_EC;
            end
            S_EC:
            begin
                cmd.emit   = tbw_pkg::EMIT_C;
                state_next = S_IDLE;
            end
            S_ELEN:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_LEN;
                state_next = S_EDOT;
            end
            S_EDOT:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_DOT;
                state_next = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (!status.mac_busy)
                begin
                    state_next = S_ECHK;
                end
            end
            S_ECHK:
            begin
                if (status.len_zero)
                begin
                    advance = 1'b1;
                end
                else if (status.dot_le0)
                begin
                    cmd.t_set  = tbw_pkg::T_ZERO;
                    state_next = S_EOX;
                end
                else if (status.dot_ge_len)
                begin
                    cmd.t_set  = tbw_pkg::T_ONE;
                    state_next = S_EOX;
                end
                else
                begin
                    cmd.div_go  = 1'b1;
                    cmd.div_sel = tbw_pkg::DIV_T;
                    state_next  = S_EDIVW;
                end
            end
            S_EDIVW:
            begin
                if (!status.div_busy)
                begin
                    state_next = S_EOX;
                end
            end
            S_EOX:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_OX;
                state_next = S_EOY;
            end
            S_EOY:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_OY;
                state_next = S_EWAIT2;
            end
            S_EWAIT2:
            begin
                if (!status.mac_busy)
                begin
                    state_next = S_EDIST;
                end
            end
            S_EDIST:
            begin
                cmd.mac_go = 1'b1;
                cmd.mac_op = tbw_pkg::OP_DIST;
                state_next = S_EWAIT3;
            end
            S_EWAIT3:
            begin
                if (!status.mac_busy)
                begin
                    state_next = S_EUPD;
                end
            end
            S_EUPD:
            begin
                cmd.best_upd = 1'b1;
                advance      = 1'b1;
            end
            S_OUT:
            begin
                if (status.best_single)
                begin
                    cmd.emit   = tbw_pkg::EMIT_SINGLE;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.emit   = tbw_pkg::EMIT_FROM;
                    state_next = S_OUT2;
                end
            end
            S_OUT2:
            begin
                cmd.emit   = tbw_pkg::EMIT_TO;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase

        if (advance)
        begin
            if (edge_reg == tbw_pkg::EDGE_CA)
            begin
                edge_next = tbw_pkg::EDGE_AB;
                if (tri_inc == n_used)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    tri_next   = tri_inc;
                    state_next = S_FT;
                end
            end
            else
            begin
                edge_next  = edge_reg + 2'd1;
                state_next = S_ELEN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            tri_reg   <= '0;
            edge_reg  <= tbw_pkg::EDGE_AB;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tri_reg   <= tri_next;
            edge_reg  <= edge_next;
            phase_reg <= phase_next;
            if (wr_en)
            begin
                count_reg <= wr_data;
            end
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule

>>> design/triangle_blend_weights.sv
// ----------------------------------------------------------------------------
// Triangle blend weights
// Barycentric blend weights of a query position over a loaded triangle set,
// with a nearest-edge fallback when no triangle holds the position.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Point and triangle
// loads write their table in that cycle and leave busy low, so loads may
// follow one another in every cycle. A query raises busy until its last
// result has been issued.
// Results appear on result for one cycle each, marked by result_valid; the
// final result of a query has last set. The receiver cannot stall them.
// The containment walk checks each triangle in turn and runs the two weight
// divisions of the hit triangle. The edge search checks each edge in turn,
// with a division when the edge parameter needs one. Both use the 17-step
// restoring divider and the three-stage shared multiply-accumulate unit.
// wr_en writes triangle_count from wr_data; write it only while busy is low.
// Reset clears triangle_count to zero and the controller to idle; table
// contents are undefined until loaded.
// ----------------------------------------------------------------------------
module triangle_blend_weights #(
    parameter int MAX_POINTS    = 16,
    parameter int MAX_TRIANGLES = 32,
    parameter int COORD_BITS    = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  tbw_pkg::in_item_t          item,
    output tbw_pkg::out_item_t         result,
    output logic                       result_valid,
    input  logic                       wr_en,
    input  logic [tbw_pkg::CNT_W-1:0]  wr_data
);

    logic             accept;
    tbw_pkg::cmd_t    cmd;
    tbw_pkg::status_t status;

    assign accept = start && !busy;

    tbw_ctrl #(.MAX_TRIANGLES(MAX_TRIANGLES)) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .action  (item.action),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .status  (status),
        .cmd     (cmd),
        .busy    (busy)
    );

    tbw_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .COORD_BITS    (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// Triangle blend weights testbench
// Loads point and triangle tables, sets the triangle count over several
// values and sends directed and random queries. A behavioral predictor of
// the containment walk and the nearest-edge fallback builds the expected
// weights, which the monitor compares field by field with every result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int NUM_POINTS = 16;
    localparam int NUM_TRIS   = 32;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] ACT_NONE = 2'd3;

    typedef struct {
        tbw_pkg::in_item_t cmd;
        bit                drain;
    } pending_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    tbw_pkg::in_item_t   item = '0;
    tbw_pkg::out_item_t  result;
    logic       result_valid;
    logic       wr_en = 1'b0;
    logic [tbw_pkg::CNT_W-1:0] wr_data = '0;

    pending_t   send_q[$];
    tbw_pkg::out_item_t  weight_q[$];
    int         fail_count = 0;
    int         cycle_count = 0;
    bit         steady = 1'b0;

    longint     pt_x[NUM_POINTS];
    longint     pt_y[NUM_POINTS];
    logic [tbw_pkg::IDX_W-1:0] tri_a[NUM_TRIS], tri_b[NUM_TRIS], tri_c[NUM_TRIS];
    int         tri_count = 0;

    longint     gen_x[NUM_POINTS];
    longint     gen_y[NUM_POINTS];
    logic [tbw_pkg::IDX_W-1:0] gen_a[NUM_TRIS], gen_b[NUM_TRIS], gen_c[NUM_TRIS];
    int         gen_count = 0;

    triangle_blend_weights u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .wr_en        (wr_en),
        .wr_data      (wr_data)
    );

    always #6 clk = ~clk;

    function automatic longint cross_turn(longint ux, longint uy, longint vx, longint vy,
                                          longint wx, longint wy);
        return (vx - ux) * (wy - uy) - (vy - uy) * (wx - ux);
    endfunction

    function automatic longint abs_of(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic bit same_side(longint n, longint whole);
        return n == 0 || ((n < 0) == (whole < 0));
    endfunction

    function automatic void push_weight(logic [tbw_pkg::IDX_W-1:0] idx, longint w, bit fin);
        tbw_pkg::out_item_t r;
        r.point_index = idx;
        r.weight      = w[tbw_pkg::WGT_W-1:0];
        r.last        = fin;
        weight_q = {weight_q, r};
    endfunction

    function automatic void predict_blend(tbw_pkg::in_item_t it);
        longint px, py, ax, ay, bx, by, cx, cy, whole, na, nb, nc, wa, wb;
        longint sx, sy, ex, ey, dx, dy, len, dot, t, ox, oy, mx, my, dist_sq;
        longint best, best_t;
        logic [tbw_pkg::IDX_W-1:0] corner[3];
        logic [tbw_pkg::IDX_W-1:0] best_from, best_to;
        bit found;
        int n;
        px = it.pos_x;
        py = it.pos_y;
        case (it.action)
            tbw_pkg::ACT_LOAD_POINT:
                if (it.slot < NUM_POINTS)
                begin
                    pt_x[it.slot] = px;
                    pt_y[it.slot] = py;
                end
            tbw_pkg::ACT_LOAD_TRI:
            begin
                tri_a[it.slot] = it.corner_a;
                tri_b[it.slot] = it.corner_b;
                tri_c[it.slot] = it.corner_c;
            end
            tbw_pkg::ACT_QUERY:
            begin
                n = tri_count < NUM_TRIS ? tri_count : NUM_TRIS;
                for (int i = 0; i < n; i++)
                begin
                    ax = pt_x[tri_a[i]]; ay = pt_y[tri_a[i]];
                    bx = pt_x[tri_b[i]]; by = pt_y[tri_b[i]];
                    cx = pt_x[tri_c[i]]; cy = pt_y[tri_c[i]];
                    whole = cross_turn(ax, ay, bx, by, cx, cy);
                    if (whole == 0)
                        continue;
                    na = cross_turn(px, py, bx, by, cx, cy);
                    nb = cross_turn(ax, ay, px, py, cx, cy);
                    nc = whole - na - nb;
                    if (same_side(na, whole) && same_side(nb, whole) && same_side(nc, whole))
                    begin
                        wa = (abs_of(na) <<< 16) / abs_of(whole);
                        wb = (abs_of(nb) <<< 16) / abs_of(whole);
                        push_weight(tri_a[i], wa, 1'b0);
                        push_weight(tri_b[i], wb, 1'b0);
                        push_weight(tri_c[i], 65536 - wa - wb, 1'b1);
                        return;
                    end
                end
                found = 1'b0;
                best = 0;
                best_t = 0;
                best_from = '0;
                best_to = '0;
                for (int i = 0; i < n; i++)
                begin
                    corner[0] = tri_a[i];
                    corner[1] = tri_b[i];
                    corner[2] = tri_c[i];
                    for (int e = 0; e < 3; e++)
                    begin
                        sx = pt_x[corner[e]]; sy = pt_y[corner[e]];
                        ex = pt_x[corner[(e + 1) % 3]]; ey = pt_y[corner[(e + 1) % 3]];
                        dx = ex - sx;
                        dy = ey - sy;
                        len = dx * dx + dy * dy;
                        if (len == 0)
                            continue;
                        dot = (px - sx) * dx + (py - sy) * dy;
                        if (dot <= 0)
                            t = 0;
                        else if (dot >= len)
                            t = 65536;
                        else
                            t = (dot <<< 16) / len;
                        ox = (sx - px) * 65536 + t * dx;
                        oy = (sy - py) * 65536 + t * dy;
                        mx = abs_of(ox) >>> 8;
                        my = abs_of(oy) >>> 8;
                        dist_sq = mx * mx + my * my;
                        if (!found || dist_sq < best)
                        begin
                            found = 1'b1;
                            best = dist_sq;
                            best_from = corner[e];
                            best_to = corner[(e + 1) % 3];
                            best_t = t;
                        end
                    end
                end
                if (!found || best_from == best_to)
                    push_weight(found ? best_from : '0, 65536, 1'b1);
                else
                begin
                    push_weight(best_from, 65536 - best_t, 1'b0);
                    push_weight(best_to, best_t, 1'b1);
                end
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        tbw_pkg::out_item_t want;
        pending_t got;
        if (rst_n)
        begin
            if (wr_en)
                tri_count = int'(wr_data);
            if (result_valid)
            begin
                if (weight_q.size() == 0)
                    report_mismatch($sformatf("unexpected result point %0d weight %0d",
                                              result.point_index, result.weight));
                else
                begin
                    want = weight_q.pop_front();
                    if (result.point_index !== want.point_index)
                        report_mismatch($sformatf("point_index %0d, expected %0d",
                                                  result.point_index, want.point_index));
                    if (result.weight !== want.weight)
                        report_mismatch($sformatf("weight %0d, expected %0d",
                                                  result.weight, want.weight));
                    if (result.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  result.last, want.last));
                end
            end
            if (start && !busy && send_q.size() > 0)
            begin
                got = send_q.pop_front();
                predict_blend(got.cmd);
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n || send_q.size() == 0)
            start <= 1'b0;
        else if (send_q[0].drain && (weight_q.size() > 0 || busy))
            start <= 1'b0;
        else if (!steady && $urandom_range(99) < 33)
            start <= 1'b0;
        else
        begin
            start <= 1'b1;
            item <= send_q[0].cmd;
        end
    end

    task automatic send_item(logic [1:0] act, int slot, int x, int y,
                             int a, int b, int c, bit drain);
        pending_t p;
        p.cmd.action   = act;
        p.cmd.slot     = slot[tbw_pkg::SLOT_W-1:0];
        p.cmd.pos_x    = x[tbw_pkg::COORD_W-1:0];
        p.cmd.pos_y    = y[tbw_pkg::COORD_W-1:0];
        p.cmd.corner_a = a[tbw_pkg::IDX_W-1:0];
        p.cmd.corner_b = b[tbw_pkg::IDX_W-1:0];
        p.cmd.corner_c = c[tbw_pkg::IDX_W-1:0];
        p.drain        = drain;
        if (act == tbw_pkg::ACT_LOAD_POINT && slot < NUM_POINTS)
        begin
            gen_x[slot] = p.cmd.pos_x;
            gen_y[slot] = p.cmd.pos_y;
        end
        if (act == tbw_pkg::ACT_LOAD_TRI)
        begin
            gen_a[slot] = p.cmd.corner_a;
            gen_b[slot] = p.cmd.corner_b;
            gen_c[slot] = p.cmd.corner_c;
        end
        send_q = {send_q, p};
    endtask

    task automatic send_query(int x, int y);
        send_item(tbw_pkg::ACT_QUERY, $urandom_range(31), x, y, $urandom_range(15),
                  $urandom_range(15), $urandom_range(15), 1'b0);
    endtask

    task automatic write_count(int value);
        while (send_q.size() > 0 || weight_q.size() > 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
        wr_en <= 1'b1;
        wr_data <= value[tbw_pkg::CNT_W-1:0];
        gen_count = value > NUM_TRIS ? NUM_TRIS : value;
        @(negedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic random_items(int count);
        int k, pick, x, y, r;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
            begin
                r = $urandom_range(3) == 0 ? 32767 : 4000;
                send_item(tbw_pkg::ACT_LOAD_POINT, $urandom_range(31),
                          $urandom_range(2 * r) - r, $urandom_range(2 * r) - r,
                          $urandom_range(15), $urandom_range(15), $urandom_range(15), 1'b0);
            end
            else if (pick < 27)
                send_item(tbw_pkg::ACT_LOAD_TRI, $urandom_range(31), $urandom(), $urandom(),
                          $urandom_range(15), $urandom_range(15), $urandom_range(15), 1'b0);
            else if (pick < 31)
                send_item(ACT_NONE, $urandom_range(31), $urandom(), $urandom(),
                          $urandom_range(15), $urandom_range(15), $urandom_range(15), 1'b0);
            else if (pick < 65 && gen_count > 0)
            begin
                k = $urandom_range(gen_count - 1);
                x = int'((gen_x[gen_a[k]] + gen_x[gen_b[k]] + gen_x[gen_c[k]]) / 3);
                y = int'((gen_y[gen_a[k]] + gen_y[gen_b[k]] + gen_y[gen_c[k]]) / 3);
                send_item(tbw_pkg::ACT_QUERY, $urandom_range(31), x, y, $urandom_range(15),
                          $urandom_range(15), $urandom_range(15), $urandom_range(99) < 4);
            end
            else if (pick < 82)
            begin
                k = $urandom_range(NUM_POINTS - 1);
                x = int'(gen_x[k] + longint'($urandom_range(600)) - 300);
                y = int'(gen_y[k] + longint'($urandom_range(600)) - 300);
                send_query(x, y);
            end
            else
                send_query($urandom(), $urandom());
        end
    endtask

    initial
    begin
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        write_count(0);
        send_item(tbw_pkg::ACT_LOAD_POINT, 0, 0, 0, 0, 0, 0, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_POINT, 1, 2560, 0, 15, 15, 15, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_POINT, 2, 0, 2560, 0, 0, 0, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_POINT, 3, 32767, 32767, 0, 0, 0, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_POINT, 4, -32768, -32768, 0, 0, 0, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_POINT, 5, -32768, 32767, 0, 0, 0, 1'b0);
        for (int s = 6; s < NUM_POINTS; s++)
            send_item(tbw_pkg::ACT_LOAD_POINT, s, $urandom_range(8000) - 4000,
                      $urandom_range(8000) - 4000, 0, 0, 0, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_POINT, 31, 1234, -1234, 0, 0, 0, 1'b0);
        send_item(ACT_NONE, 31, -1, -1, 15, 15, 15, 1'b0);
        send_query(0, 0);
        send_query(32767, -32768);
        send_item(tbw_pkg::ACT_LOAD_TRI, 0, 0, 0, 0, 1, 2, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_TRI, 1, 0, 0, 3, 4, 5, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_TRI, 2, 0, 0, 0, 0, 1, 1'b0);
        send_item(tbw_pkg::ACT_LOAD_TRI, 3, 0, 0, 1, 1, 1, 1'b0);
        for (int s = 4; s < NUM_TRIS; s++)
            send_item(tbw_pkg::ACT_LOAD_TRI, s, 0, 0, $urandom_range(15), $urandom_range(15),
                      $urandom_range(15), 1'b0);

        write_count(1);
        send_query(256, 256);
        send_query(0, 0);
        send_query(1280, 1280);
        send_query(-1000, -1000);
        send_query(9000, -5);
        send_query(-32768, 32767);
        send_item(tbw_pkg::ACT_LOAD_TRI, 0, 0, 0, 7, 7, 7, 1'b0);
        send_query(100, 100);
        send_item(tbw_pkg::ACT_LOAD_TRI, 0, 0, 0, 0, 1, 2, 1'b0);
        send_query(100, 100);

        write_count(4);
        send_query(30000, -30000);
        send_query(-20000, 100);
        steady = 1'b1;
        random_items(50);
        while (send_q.size() > 0)
            @(negedge clk);
        steady = 1'b0;

        write_count(32);
        random_items(60);
        send_item(tbw_pkg::ACT_QUERY, 0, 300, 300, 0, 0, 0, 1'b1);

        write_count(63);
        random_items(30);

        write_count($urandom_range(31, 2));
        random_items(30);

        while (send_q.size() > 0 || weight_q.size() > 0 || busy)
            @(negedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

>>> sim.f
design/tbw_pkg.sv
design/tbw_ram.sv
design/tbw_datapath.sv
design/tbw_ctrl.sv
design/triangle_blend_weights.sv
tb/sv/tb_top.sv
